// ----- src/gvp_pkg.sv -----
`timescale 1ns / 1ps

package gvp_pkg;

	localparam int CORDIC_STAGES_DEF = 20;
	localparam int COORD_BITS_DEF    = 8;

	localparam int FIELD_BITS  = 8;
	localparam int SCALE_BITS  = 10;
	localparam int PRE_SHIFT   = 20;
	localparam int ANGLE_FRAC  = 24;
	localparam int ZW          = 34;
	localparam int DIST_BITS   = 23;
	localparam int BEARING_BITS = 17;

	localparam logic signed [ZW-1:0] DEG180_Q24 = 34'sd3019898880;
	localparam logic signed [ZW-1:0] BEARING_LIMIT = 34'sd46080;
	localparam logic [31:0] DIST_MAX = 32'd8388607;

	localparam logic [SCALE_BITS-1:0] CELL_WIDTH_RST  = 10'd225;
	localparam logic [SCALE_BITS-1:0] CELL_HEIGHT_RST = 10'd200;

	localparam logic [29:0] ATAN_DEG_Q24 [32] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115,
		30'd57,        30'd29,        30'd14,        30'd7,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef enum logic [1:0] {
		REG_CELL_WIDTH,
		REG_CELL_HEIGHT,
		REG_BEARING_SWAP
	} cfg_reg_t;

	typedef struct packed {
		logic [SCALE_BITS-1:0] cell_width;
		logic [SCALE_BITS-1:0] cell_height;
		logic                  swap;
	} cfg_t;

endpackage

// ----- src/grid_vector_to_polar.sv -----
`timescale 1ns / 1ps

// Distance and bearing between two grid cells, one transfer per cycle sustained
// while m_tready holds. Each item passes four front stages (coordinate
// differences, scaling by the cell size, squaring and quadrant folding, sum of
// squares), then a row of max(CORDIC_STAGES, COORD_BITS + 15) cells, of which
// the first CORDIC_STAGES each perform one CORDIC micro-rotation and the first
// COORD_BITS + 15 each produce one bit of the square root, then one output
// register for rounding and clamping. Every stage holds its own valid bit, so
// bubbles close up and new items enter while a result waits.
// Registers: 0 cell width in mm (reset 225), 1 cell height in mm (reset 200),
// 2 swap the scales for the bearing only (reset 0); other indexes are ignored.

module grid_vector_to_polar
	import gvp_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // start_col, start_row, target_col, target_row
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata, // distance_q4, bearing_q8
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [SCALE_BITS-1:0] cfg_data
);

	localparam int MAG   = COORD_BITS + SCALE_BITS;
	localparam int XW    = MAG + PRE_SHIFT + 3;
	localparam int SW    = 2 * MAG + 9;
	localparam int RW    = MAG + 5;
	localparam int NCELL = (CORDIC_STAGES > RW) ? CORDIC_STAGES : RW;

	cfg_t cfg_q;

	logic v_c [NCELL+1];
	logic rdy_c [NCELL+1];
	logic signed [XW-1:0] x_c [NCELL+1];
	logic signed [XW-1:0] y_c [NCELL+1];
	logic signed [ZW-1:0] z_c [NCELL+1];
	logic [SW-1:0] rem_c [NCELL+1];
	logic [RW-1:0] root_c [NCELL+1];

	logic [DIST_BITS-1:0] distance_q4;
	logic signed [BEARING_BITS-1:0] bearing_q8;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width <= CELL_WIDTH_RST;
			cfg_q.cell_height <= CELL_HEIGHT_RST;
			cfg_q.swap <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELL_WIDTH: cfg_q.cell_width <= cfg_data;
				REG_CELL_HEIGHT: cfg_q.cell_height <= cfg_data;
				REG_BEARING_SWAP: cfg_q.swap <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gvp_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.start_col(s_tdata[7:0]),
		.start_row(s_tdata[15:8]),
		.target_col(s_tdata[23:16]),
		.target_row(s_tdata[31:24]),
		.out_valid(v_c[0]),
		.out_ready(rdy_c[0]),
		.x_out(x_c[0]),
		.y_out(y_c[0]),
		.z_out(z_c[0]),
		.rem_out(rem_c[0])
	);

	assign root_c[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		gvp_cell #(
			.COORD_BITS(COORD_BITS),
			.CORDIC_STAGES(CORDIC_STAGES),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(v_c[i]),
			.in_ready(rdy_c[i]),
			.x_in(x_c[i]),
			.y_in(y_c[i]),
			.z_in(z_c[i]),
			.rem_in(rem_c[i]),
			.root_in(root_c[i]),
			.out_valid(v_c[i+1]),
			.out_ready(rdy_c[i+1]),
			.x_out(x_c[i+1]),
			.y_out(y_c[i+1]),
			.z_out(z_c[i+1]),
			.rem_out(rem_c[i+1]),
			.root_out(root_c[i+1])
		);
	end

	gvp_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_c[NCELL]),
		.in_ready(rdy_c[NCELL]),
		.z_in(z_c[NCELL]),
		.rem_in(rem_c[NCELL]),
		.root_in(root_c[NCELL]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.distance_q4(distance_q4),
		.bearing_q8(bearing_q8)
	);

	assign m_tdata = {bearing_q8, distance_q4};

`ifndef NO_ASSERTIONS
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[39:23]) <= 17'sd46080 &&
			$signed(m_tdata[39:23]) >= -17'sd46080))
		else $error("bearing outside +-180 degrees");

	a_out_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> rdy_c[NCELL])
		else $error("empty output register refuses the chain");

	a_chain_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_c[NCELL] && rdy_c[NCELL]) |=> m_tvalid)
		else $error("transfer from the chain lost at the output");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !v_c[NCELL]) |=> !m_tvalid)
		else $error("result appeared without a transfer from the chain");
`endif

endmodule

// ----- src/gvp_front.sv -----
`timescale 1ns / 1ps

module gvp_front
	import gvp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [FIELD_BITS-1:0] start_col,
	input  logic [FIELD_BITS-1:0] start_row,
	input  logic [FIELD_BITS-1:0] target_col,
	input  logic [FIELD_BITS-1:0] target_row,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] x_out,
	output logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic [2*(COORD_BITS+SCALE_BITS)+8:0] rem_out
);

	localparam int DW  = COORD_BITS + 1;
	localparam int MAG = COORD_BITS + SCALE_BITS;
	localparam int PW  = MAG + 1;
	localparam int SQW = 2 * MAG;
	localparam int XW  = MAG + PRE_SHIFT + 3;
	localparam int SW  = 2 * MAG + 9;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] px_s2, py_s2, bx_s2, by_s2;
	logic [SQW-1:0] sqx_s3, sqy_s3;
	logic signed [XW-1:0] x_s3, y_s3, x_s4, y_s4;
	logic signed [ZW-1:0] z_s3, z_s4;
	logic [SW-1:0] rem_s4;

	logic signed [PW-1:0] px_n, py_n, bx_n, by_n;
	logic signed [PW-1:0] ax_w, ay_w;
	logic [MAG-1:0] ax, ay;
	logic signed [XW-1:0] bxe, bye, x_n, y_n;
	logic signed [ZW-1:0] z_n;
	logic [SCALE_BITS-1:0] bscale_x, bscale_y;

	assign rdy_s4 = !v_s4 || out_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		bscale_x = cfg.swap ? cfg.cell_height : cfg.cell_width;
		bscale_y = cfg.swap ? cfg.cell_width : cfg.cell_height;
		px_n = PW'(dx_s1) * PW'($signed({1'b0, cfg.cell_width}));
		py_n = PW'(dy_s1) * PW'($signed({1'b0, cfg.cell_height}));
		bx_n = PW'(dx_s1) * PW'($signed({1'b0, bscale_x}));
		by_n = PW'(dy_s1) * PW'($signed({1'b0, bscale_y}));
	end

	always_comb begin
		ax_w = px_s2[PW-1] ? -px_s2 : px_s2;
		ay_w = py_s2[PW-1] ? -py_s2 : py_s2;
		ax = ax_w[MAG-1:0];
		ay = ay_w[MAG-1:0];
		bxe = XW'(bx_s2);
		bye = XW'(by_s2);
		if (bx_s2[PW-1]) begin
			x_n = (-bxe) <<< PRE_SHIFT;
			y_n = (-bye) <<< PRE_SHIFT;
			z_n = by_s2[PW-1] ? -DEG180_Q24 : DEG180_Q24;
		end else begin
			x_n = bxe <<< PRE_SHIFT;
			y_n = bye <<< PRE_SHIFT;
			z_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dx_s1 <= $signed(DW'(COORD_BITS'(target_col))) - $signed(DW'(COORD_BITS'(start_col)));
			dy_s1 <= $signed(DW'(COORD_BITS'(target_row))) - $signed(DW'(COORD_BITS'(start_row)));
		end
		if (rdy_s2 && v_s1) begin
			px_s2 <= px_n;
			py_s2 <= py_n;
			bx_s2 <= bx_n;
			by_s2 <= by_n;
		end
		if (rdy_s3 && v_s2) begin
			sqx_s3 <= SQW'(ax) * SQW'(ax);
			sqy_s3 <= SQW'(ay) * SQW'(ay);
			x_s3 <= x_n;
			y_s3 <= y_n;
			z_s3 <= z_n;
		end
		if (rdy_s4 && v_s3) begin
			rem_s4 <= (SW'(sqx_s3) + SW'(sqy_s3)) << 8;
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			z_s4 <= z_s3;
		end
	end

	assign out_valid = v_s4;
	assign x_out = x_s4;
	assign y_out = y_s4;
	assign z_out = z_s4;
	assign rem_out = rem_s4;

endmodule

// ----- src/gvp_cell.sv -----
`timescale 1ns / 1ps

module gvp_cell
	import gvp_pkg::*;
#(
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int IDX           = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] x_in,
	input  logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [2*(COORD_BITS+SCALE_BITS)+8:0] rem_in,
	input  logic [COORD_BITS+SCALE_BITS+4:0] root_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] x_out,
	output logic signed [COORD_BITS+SCALE_BITS+PRE_SHIFT+2:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output logic [2*(COORD_BITS+SCALE_BITS)+8:0] rem_out,
	output logic [COORD_BITS+SCALE_BITS+4:0] root_out
);

	localparam int MAG = COORD_BITS + SCALE_BITS;
	localparam int XW  = MAG + PRE_SHIFT + 3;
	localparam int SW  = 2 * MAG + 9;
	localparam int RW  = MAG + 5;
	localparam int TW  = SW + 2;
	localparam bit DO_ROT  = IDX < CORDIC_STAGES;
	localparam bit DO_SQRT = IDX < RW;
	localparam int K = DO_SQRT ? RW - 1 - IDX : 0;

	logic signed [XW-1:0] xs, ys, x_n, y_n;
	logic signed [ZW-1:0] z_n, ang;
	logic [TW-1:0] trial;
	logic [SW-1:0] rem_n;
	logic [RW-1:0] root_n;
	logic valid_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		ang = $signed(ZW'(ATAN_DEG_Q24[IDX]));
		x_n = x_in;
		y_n = y_in;
		z_n = z_in;
		if (DO_ROT) begin
			if (!y_in[XW-1] && (y_in != '0)) begin
				x_n = x_in + ys;
				y_n = y_in - xs;
				z_n = z_in + ang;
			end else if (y_in[XW-1]) begin
				x_n = x_in - ys;
				y_n = y_in + xs;
				z_n = z_in - ang;
			end
		end
	end

	always_comb begin
		trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
		rem_n = rem_in;
		root_n = root_in;
		if (DO_SQRT && (TW'(rem_in) >= trial)) begin
			rem_n = rem_in - trial[SW-1:0];
			root_n = root_in | (RW'(1) << K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_out <= x_n;
			y_out <= y_n;
			z_out <= z_n;
			rem_out <= rem_n;
			root_out <= root_n;
		end
	end

	assign out_valid = valid_q;

endmodule

// ----- src/gvp_back.sv -----
`timescale 1ns / 1ps

module gvp_back
	import gvp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ZW-1:0] z_in,
	input  logic [2*(COORD_BITS+SCALE_BITS)+8:0] rem_in,
	input  logic [COORD_BITS+SCALE_BITS+4:0] root_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [DIST_BITS-1:0] distance_q4,
	output logic signed [BEARING_BITS-1:0] bearing_q8
);

	localparam int MAG = COORD_BITS + SCALE_BITS;
	localparam int SW  = 2 * MAG + 9;
	localparam int RW  = MAG + 5;

	logic [RW:0] rnd;
	logic [31:0] rnd_w;
	logic [DIST_BITS-1:0] dist_n;
	logic signed [ZW-1:0] zr, zc;
	logic valid_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		rnd = (RW + 1)'(root_in) + (RW + 1)'(rem_in > SW'(root_in));
		rnd_w = 32'(rnd);
		dist_n = (rnd_w > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : rnd_w[DIST_BITS-1:0];
		zr = (z_in + (ZW'(1) <<< (ANGLE_FRAC - 9))) >>> (ANGLE_FRAC - 8);
		if (zr > BEARING_LIMIT) begin
			zc = BEARING_LIMIT;
		end else if (zr < -BEARING_LIMIT) begin
			zc = -BEARING_LIMIT;
		end else begin
			zc = zr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			distance_q4 <= dist_n;
			bearing_q8 <= zc[BEARING_BITS-1:0];
		end
	end

	assign out_valid = valid_q;

endmodule
